[hw/rtl/kct_pkg.sv]
// kct_pkg: shared types and constants for the keyed counter table.
// No dependencies; used by the interfaces and by keyed_counter_table.

package kct_pkg;

	localparam int KEY_W = 32;
	localparam int OP_W  = 2;
	localparam int TR_W  = 16;

	// operation codes; the spare code behaves as a query
	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/kct_if.sv]
// kct_if: valid/ready channel interfaces for the keyed counter table.
// Depends on kct_pkg for field widths.

interface kct_req_if;
	logic                             valid;
	logic                             ready;
	logic [kct_pkg::OP_W-1:0]         operation;
	logic signed [kct_pkg::KEY_W-1:0] serial_number;

	modport source (output valid, output operation, output serial_number, input ready);
	modport sink   (input valid, input operation, input serial_number, output ready);
endinterface

interface kct_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [kct_pkg::TR_W-1:0]  times_recycled;
	logic                      table_full;

	modport source (output valid, output found, output times_recycled, output table_full,
		input ready);
	modport sink   (input valid, input found, input times_recycled, input table_full,
		output ready);
endinterface

[hw/rtl/keyed_counter_table.sv]
// keyed_counter_table: table of distinct 32-bit keys, each with a saturating count.
// Each word is answered by a full linear scan over the single RAM read port;
// no new word is accepted until its scan and finish step are over.
// A new request is taken while the previous result still waits in the output register.
// Reset: asynchronous; afterwards a clearing pass zeroes the RAM,
// during which no request is accepted. Depends on kct_pkg, kct_if, kct_ram.

module keyed_counter_table #(
	parameter int CAPACITY   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	kct_req_if.sink     req,
	kct_rsp_if.source   rsp
);

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = IDX_W + 1;
	localparam int WORD_W  = 1 + kct_pkg::KEY_W + COUNT_BITS;
	localparam int VLD_POS = WORD_W - 1;

	kct_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]          scan_cnt_q;
	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          rd_idx_s1;
	logic [kct_pkg::OP_W-1:0]  op_q;
	logic [kct_pkg::KEY_W-1:0] key_q;
	logic                      hit_q, free_q;
	logic [IDX_W-1:0]          hit_idx_q, free_idx_q;
	logic [COUNT_BITS-1:0]     hit_cnt_q;

	logic                      rsp_valid_q;
	logic                      rsp_found_q, rsp_full_q;
	logic [kct_pkg::TR_W-1:0]  rsp_times_q;

	logic                      wr_en, rd_en;
	logic [IDX_W-1:0]          wr_addr;
	logic [WORD_W-1:0]         wr_data, rd_data;

	logic                      accept, out_free, finish_go, scan_done;
	logic                      row_valid, row_match;
	logic [kct_pkg::KEY_W-1:0] row_key;
	logic [COUNT_BITS-1:0]     row_cnt, cnt_inc;
	logic                      res_found, res_full;
	logic [kct_pkg::TR_W-1:0]  res_times;

	kct_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign row_valid = rd_data[VLD_POS];
	assign row_key   = rd_data[COUNT_BITS +: kct_pkg::KEY_W];
	assign row_cnt   = rd_data[COUNT_BITS-1:0];
	assign row_match = rd_vld_s1 && row_valid && (row_key == key_q);

	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign scan_done = (scan_cnt_q == CNT_W'(CAPACITY)) && !rd_vld_s1;
	assign finish_go = (state_q == kct_pkg::ST_FINISH) && out_free;
	assign cnt_inc   = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kct_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM port control and result formation
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = scan_cnt_q[IDX_W-1:0];
		wr_data   = '0;
		res_found = hit_q;
		res_full  = 1'b0;
		res_times = '0;
		unique case (state_q)
			kct_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (scan_cnt_q == CNT_W'(CAPACITY - 1)) begin
					state_d = kct_pkg::ST_IDLE;
				end
			end
			kct_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = kct_pkg::ST_SCAN;
				end
			end
			kct_pkg::ST_SCAN: begin
				rd_en = (scan_cnt_q < CNT_W'(CAPACITY));
				if (scan_done) begin
					state_d = kct_pkg::ST_FINISH;
				end
			end
			kct_pkg::ST_FINISH: begin
				priority if (op_q == kct_pkg::OP_ADD) begin
					if (hit_q) begin
						wr_en     = finish_go;
						wr_addr   = hit_idx_q;
						wr_data   = {1'b1, key_q, cnt_inc};
						res_times = kct_pkg::TR_W'(cnt_inc);
					end else if (free_q) begin
						wr_en   = finish_go;
						wr_addr = free_idx_q;
						wr_data = {1'b1, key_q, COUNT_BITS'(0)};
					end else begin
						res_full = 1'b1;
					end
				end else if (op_q == kct_pkg::OP_REMOVE) begin
					wr_en   = finish_go && hit_q;
					wr_addr = hit_idx_q;
				end else begin
					// query, and the spare code
					if (hit_q) begin
						res_times = kct_pkg::TR_W'(hit_cnt_q);
					end
				end
				if (out_free) begin
					state_d = kct_pkg::ST_IDLE;
				end
			end
			default: state_d = kct_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == kct_pkg::ST_CLEAR) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end else if (accept) begin
				scan_cnt_q <= '0;
			end else if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (row_match) begin
					hit_q <= 1'b1;
				end
				// lowest free slot wins
				if (rd_vld_s1 && !row_valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (accept) begin
			op_q  <= req.operation;
			key_q <= req.serial_number;
		end
		if (row_match) begin
			hit_idx_q <= rd_idx_s1;
			hit_cnt_q <= row_cnt;
		end
		if (rd_vld_s1 && !row_valid && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (finish_go) begin
			rsp_found_q <= res_found;
			rsp_times_q <= res_times;
			rsp_full_q  <= res_full;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.found          = rsp_found_q;
	assign rsp.times_recycled = rsp_times_q;
	assign rsp.table_full     = rsp_full_q;

	// no RAM write may land while a scan is reading
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kct_pkg::ST_SCAN |-> !wr_en)
		else $error("RAM write during scan");

	// trackers start clean for every word
	a_trackers_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !hit_q && !free_q)
		else $error("match trackers not cleared on accept");

	// a result is only produced out of the finish step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == kct_pkg::ST_FINISH))
		else $error("result word appeared outside finish");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= CNT_W'(CAPACITY))
		else $error("scan counter overran table");

	// a full flag is never paired with a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_full_q |-> !rsp_found_q)
		else $error("table_full reported on a present key");

endmodule

[hw/rtl/kct_ram.sv]
// kct_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module kct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
